// ----- rtl/gsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and codes of the generational slot allocator
// Item layouts, command, status and mark codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int CMD_W       = 4;
    localparam int IN_INDEX_W  = 8;
    localparam int GEN_W       = 16;
    localparam int BITS_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_INDEX_W = 6;
    localparam int COUNT_W     = 7;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 64;
    localparam int ITEM_W      = CMD_W + IN_INDEX_W + GEN_W + BITS_W;

    localparam logic [CMD_W-1:0] CMD_CREATE      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MARK        = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_BITS    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CHECK       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CLEANUP     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DESTROY_ALL = 4'd6;
    localparam logic [CMD_W-1:0] CMD_COUNT       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FIND        = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

    localparam logic [1:0] MARK_NONE    = 2'd0;
    localparam logic [1:0] MARK_MARKED  = 2'd1;
    localparam logic [1:0] MARK_CLEANED = 2'd2;

    typedef struct packed {
        logic [BITS_W-1:0]     bits;
        logic [GEN_W-1:0]      generation;
        logic [IN_INDEX_W-1:0] slot_index;
        logic [CMD_W-1:0]      cmd;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]     match_count;
        logic [BITS_W-1:0]      out_bits;
        logic [GEN_W-1:0]       out_generation;
        logic [OUT_INDEX_W-1:0] out_index;
        logic [STATUS_W-1:0]    status;
    } res_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CREATE,
        KIND_HANDLE,
        KIND_SCAN
    } kind_t;

    typedef enum logic [1:0] {
        ADR_CMD,
        ADR_STK,
        ADR_SCAN,
        ADR_SCAN_NEXT
    } adr_sel_t;

    typedef struct packed {
        logic     ld;
        logic     stk_rd;
        logic     slot_rd;
        adr_sel_t addr_sel;
        logic     apply;
        logic     scan_inc;
        logic     push_final;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  fc_zero;
        logic  hit;
        logic  stop;
        logic  pend_valid;
        logic  out_busy;
        logic  scan_last;
    } dp_stat_t;

endpackage

// ----- rtl/gsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_ctrl: command sequencer of the slot allocator
// Takes an item, dispatches on its kind, steps the datapath through the
// slot reads, updates and sweeps, and hands the final result to the output.
// ----------------------------------------------------------------------------
module gsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gsa_pkg::dp_stat_t stat,
    output gsa_pkg::dp_cmd_t  cmd
);
    import gsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_STK,
        S_EVAL,
        S_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.ld     = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.kind)
                    KIND_CREATE: begin
                        if (stat.fc_zero) begin
                            state_next = S_END;
                        end else begin
                            cmd.stk_rd = 1'b1;
                            state_next = S_STK;
                        end
                    end
                    KIND_HANDLE: begin
                        cmd.slot_rd  = 1'b1;
                        cmd.addr_sel = ADR_CMD;
                        state_next   = S_EVAL;
                    end
                    KIND_SCAN: begin
                        cmd.slot_rd  = 1'b1;
                        cmd.addr_sel = ADR_SCAN;
                        state_next   = S_EVAL;
                    end
                    KIND_NONE: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_STK: begin
                cmd.slot_rd  = 1'b1;
                cmd.addr_sel = ADR_STK;
                state_next   = S_EVAL;
            end
            S_EVAL: begin
                if (stat.kind != KIND_SCAN) begin
                    cmd.apply  = 1'b1;
                    state_next = S_END;
                end else if (!(stat.hit && stat.pend_valid && stat.out_busy)) begin
                    cmd.apply = 1'b1;
                    if (stat.stop || stat.scan_last) begin
                        state_next = S_END;
                    end else begin
                        cmd.scan_inc = 1'b1;
                        cmd.slot_rd  = 1'b1;
                        cmd.addr_sel = ADR_SCAN_NEXT;
                    end
                end
            end
            S_END: begin
                if (!stat.out_busy) begin
                    cmd.push_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/gsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_datapath: slot memory, free stack and result registers
// Holds the per-slot records and the free slot stack, evaluates the slot
// read for the current command, and keeps a pending and an output result.
// ----------------------------------------------------------------------------
module gsa_datapath #(
    parameter int SLOTS     = 64,
    parameter int GEN_BITS  = 16,
    parameter int MASK_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gsa_pkg::item_t    item,
    input  gsa_pkg::dp_cmd_t  cmd,
    output gsa_pkg::dp_stat_t stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gsa_pkg::res_t     m_res,
    output logic              m_last
);
    import gsa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [GEN_BITS-1:0]  live_gen;
        logic [GEN_BITS-1:0]  next_gen;
        logic [MASK_BITS-1:0] mask;
        logic [1:0]           mark;
    } row_t;

    // latched item
    logic [CMD_W-1:0]      cmd_reg;
    logic [IN_INDEX_W-1:0] idx_reg;
    logic [GEN_W-1:0]      gen_reg;
    logic [MASK_BITS-1:0]  q_reg;

    logic [IDX_W-1:0]   scan_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]   fc_reg;

    // slot records
    row_t             slot_mem [SLOTS];
    logic [SLOTS-1:0] row_valid_reg;
    row_t             row_q_reg;
    logic             row_vq_reg;
    logic [IDX_W-1:0] rd_addr_reg;

    // free stack
    logic [IDX_W-1:0] stk_mem [SLOTS];
    logic [SLOTS-1:0] stk_valid_reg;
    logic [IDX_W-1:0] stk_q_reg;
    logic             stk_vq_reg;
    logic [IDX_W-1:0] stk_pos_reg;

    logic pend_valid_reg;
    res_t pend_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic out_last_reg;

    kind_t                kind;
    row_t                 row;
    logic                 live;
    logic                 match;
    logic                 handle_ok;
    logic [IDX_W-1:0]     stk_slot;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     stk_pos;
    logic [GEN_BITS-1:0]  fin_gen;
    logic [GEN_BITS-1:0]  create_gen;
    logic [OUT_INDEX_W-1:0] slot_out_idx;
    logic                 hit;
    logic                 stop;
    logic                 wr_en;
    row_t                 wr_row;
    logic                 fin;
    logic                 pop;
    logic                 cnt_inc;
    res_t                 new_res;
    res_t                 final_res;
    logic                 push_mid;
    logic                 do_push;

    always_comb begin
        unique case (cmd_reg)
            CMD_CREATE: kind = KIND_CREATE;
            CMD_DESTROY, CMD_MARK, CMD_ADD_BITS, CMD_CHECK: kind = KIND_HANDLE;
            CMD_CLEANUP, CMD_DESTROY_ALL, CMD_COUNT, CMD_FIND: kind = KIND_SCAN;
            default: kind = KIND_NONE;
        endcase
    end

    assign row       = row_vq_reg ? row_q_reg : '0;
    assign live      = (row.live_gen != '0);
    assign match     = live && ((row.mask & q_reg) == q_reg);
    assign handle_ok = (32'(idx_reg) < SLOTS) && (gen_reg != '0)
                       && (32'(row.live_gen) == 32'(gen_reg));
    assign stk_slot  = stk_vq_reg ? stk_q_reg : IDX_W'(SLOTS - 1) - stk_pos_reg;
    assign stk_pos   = IDX_W'(fc_reg - 1'b1);
    assign slot_out_idx = OUT_INDEX_W'(rd_addr_reg);

    always_comb begin
        fin_gen = GEN_BITS'(row.live_gen + 1'b1);
        if (fin_gen == '0) begin
            fin_gen = GEN_BITS'(1);
        end
        create_gen = (row.next_gen == '0) ? GEN_BITS'(1) : row.next_gen;
    end

    always_comb begin
        unique case (cmd.addr_sel)
            ADR_CMD:       rd_addr = idx_reg[IDX_W-1:0];
            ADR_STK:       rd_addr = stk_slot;
            ADR_SCAN:      rd_addr = scan_reg;
            ADR_SCAN_NEXT: rd_addr = IDX_W'(scan_reg + 1'b1);
            default:       rd_addr = scan_reg;
        endcase
    end

    // per-slot evaluation of the record just read
    always_comb begin
        hit     = 1'b0;
        stop    = 1'b0;
        wr_en   = 1'b0;
        wr_row  = row;
        fin     = 1'b0;
        pop     = 1'b0;
        cnt_inc = 1'b0;
        new_res = '0;
        if (kind == KIND_HANDLE) begin
            hit = 1'b1;
            if (handle_ok) begin
                new_res.status         = ST_OK;
                new_res.out_index      = slot_out_idx;
                new_res.out_generation = gen_reg;
            end else begin
                new_res.status = ST_INVALID;
            end
        end
        unique case (cmd_reg)
            CMD_CREATE: begin
                hit                    = 1'b1;
                pop                    = 1'b1;
                wr_en                  = 1'b1;
                wr_row.live_gen        = create_gen;
                wr_row.mask            = '0;
                new_res.status         = ST_OK;
                new_res.out_index      = slot_out_idx;
                new_res.out_generation = GEN_W'(create_gen);
            end
            CMD_DESTROY: begin
                if (handle_ok) begin
                    new_res.out_bits = BITS_W'(row.mask);
                    fin              = 1'b1;
                end
            end
            CMD_MARK: begin
                if (handle_ok && row.mark == MARK_NONE) begin
                    wr_en       = 1'b1;
                    wr_row.mark = MARK_MARKED;
                end
            end
            CMD_ADD_BITS: begin
                if (handle_ok) begin
                    wr_en       = 1'b1;
                    wr_row.mask = row.mask | q_reg;
                end
            end
            CMD_CHECK: begin
                if (handle_ok) begin
                    new_res.out_bits = BITS_W'(row.mask);
                end
            end
            CMD_CLEANUP: begin
                if (row.mark == MARK_MARKED) begin
                    wr_en = 1'b1;
                    if (!live) begin
                        wr_row.mark = MARK_NONE;
                    end else begin
                        hit                    = 1'b1;
                        wr_row.mark            = MARK_CLEANED;
                        new_res.status         = ST_OK;
                        new_res.out_index      = slot_out_idx;
                        new_res.out_generation = GEN_W'(row.live_gen);
                        new_res.out_bits       = BITS_W'(row.mask);
                    end
                end
            end
            CMD_DESTROY_ALL: begin
                if (row.mark != MARK_NONE) begin
                    if (!live) begin
                        wr_en       = 1'b1;
                        wr_row.mark = MARK_NONE;
                    end else begin
                        hit                    = 1'b1;
                        fin                    = 1'b1;
                        new_res.status         = ST_OK;
                        new_res.out_index      = slot_out_idx;
                        new_res.out_generation = GEN_W'(row.live_gen);
                        new_res.out_bits       = (row.mark == MARK_MARKED)
                                                 ? BITS_W'(row.mask) : '0;
                    end
                end
            end
            CMD_COUNT: begin
                cnt_inc = match;
            end
            CMD_FIND: begin
                if (match) begin
                    hit                    = 1'b1;
                    stop                   = 1'b1;
                    new_res.status         = ST_OK;
                    new_res.out_index      = slot_out_idx;
                    new_res.out_generation = GEN_W'(row.live_gen);
                    new_res.out_bits       = BITS_W'(row.mask);
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        if (fin) begin
            wr_en           = 1'b1;
            wr_row.live_gen = '0;
            wr_row.next_gen = fin_gen;
            wr_row.mask     = '0;
            wr_row.mark     = MARK_NONE;
        end
    end

    always_comb begin
        final_res = '0;
        if (pend_valid_reg) begin
            final_res = pend_reg;
        end else if (cmd_reg == CMD_COUNT) begin
            final_res.status      = ST_OK;
            final_res.match_count = cnt_reg;
        end else begin
            final_res.status = ST_NONE;
        end
    end

    assign push_mid = cmd.apply && hit && pend_valid_reg;
    assign do_push  = push_mid || cmd.push_final;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg         <= CNT_W'(SLOTS);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
            stk_valid_reg  <= '0;
        end else begin
            if (cmd.ld) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.apply && hit) begin
                pend_valid_reg <= 1'b1;
            end
            if (do_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.apply && wr_en) begin
                row_valid_reg[rd_addr_reg] <= 1'b1;
            end
            if (cmd.apply && pop) begin
                fc_reg <= CNT_W'(fc_reg - 1'b1);
            end else if (cmd.apply && fin && fc_reg < SLOTS) begin
                stk_valid_reg[fc_reg[IDX_W-1:0]] <= 1'b1;
                fc_reg                           <= CNT_W'(fc_reg + 1'b1);
            end
        end
    end

    // payload, memories and read registers
    always_ff @(posedge aclk) begin
        if (cmd.ld) begin
            cmd_reg  <= item.cmd;
            idx_reg  <= item.slot_index;
            gen_reg  <= item.generation;
            q_reg    <= item.bits[MASK_BITS-1:0];
            scan_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cmd.scan_inc) begin
                scan_reg <= IDX_W'(scan_reg + 1'b1);
            end
            if (cmd.apply && cnt_inc) begin
                cnt_reg <= COUNT_W'(cnt_reg + 1'b1);
            end
        end
        if (cmd.slot_rd) begin
            row_q_reg   <= slot_mem[rd_addr];
            row_vq_reg  <= row_valid_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.apply && wr_en) begin
            slot_mem[rd_addr_reg] <= wr_row;
        end
        if (cmd.stk_rd) begin
            stk_q_reg   <= stk_mem[stk_pos];
            stk_vq_reg  <= stk_valid_reg[stk_pos];
            stk_pos_reg <= stk_pos;
        end
        if (cmd.apply && fin && fc_reg < SLOTS) begin
            stk_mem[fc_reg[IDX_W-1:0]] <= rd_addr_reg;
        end
        if (cmd.apply && hit) begin
            pend_reg <= new_res;
        end
        if (push_mid) begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b0;
        end else if (cmd.push_final) begin
            out_reg      <= final_res;
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        stat            = '0;
        stat.kind       = kind;
        stat.fc_zero    = (fc_reg == '0);
        stat.hit        = hit;
        stat.stop       = stop;
        stat.pend_valid = pend_valid_reg;
        stat.out_busy   = out_valid_reg && !m_tready;
        stat.scan_last  = (scan_reg == IDX_W'(SLOTS - 1));
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;
    assign m_last   = out_last_reg;

endmodule

// ----- rtl/generational_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator: slot allocator with generation-checked handles
//
//   channel   direction   signals                      item
//   s_        in          s_tvalid s_tready s_tdata    one command
//   m_        out         m_tvalid m_tready m_tdata    one result, tlast ends
//                         m_tlast                      the results of a command
//
// Create reads the free stack, then the slot; handle commands read the slot
// only. Sweeps, count and find visit one slot per cycle via the registered
// slot memory read while the output does not stall. Reset is synchronous and
// clears per-entry valid bits, so no clearing pass is needed. A command is
// accepted while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
    parameter int SLOTS     = 64,
    parameter int GEN_BITS  = 16,
    parameter int MASK_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[3:0], slot_index[11:4], generation[27:12], bits[59:28]
    input  logic [gsa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], out_index[7:2], out_generation[23:8], out_bits[55:24],
    // match_count[62:56]
    output logic [gsa_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import gsa_pkg::*;

    item_t    item;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    res_t     res;

    assign item = s_tdata[ITEM_W-1:0];

    gsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsa_datapath #(
        .SLOTS     (SLOTS),
        .GEN_BITS  (GEN_BITS),
        .MASK_BITS (MASK_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res),
        .m_last   (m_tlast)
    );

    assign m_tdata = {1'b0, res.match_count, res.out_bits, res.out_generation,
                      res.out_index, res.status};

`ifndef ASSERT_OFF
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status != ST_OK |-> m_tlast)
        else $error("error result not marked last");

    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in progress");

    a_count_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.match_count != '0 |-> res.status == ST_OK && m_tlast
            && res.out_index == '0)
        else $error("count result malformed");
`endif

endmodule

// ----- verif/gsa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_checker: result checker for the generational slot allocator
// Watches both stream channels. Every accepted command runs through a
// behavioral copy of the slot allocator, and the results it yields are
// queued. Every accepted result item is compared field by field with the
// oldest queued one. The failure count and the number of results still
// due go back to the testbench top.
// ----------------------------------------------------------------------------
module gsa_checker
    import gsa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   error_count,
    output int                   outstanding
);

    localparam int RES_W = $bits(res_t);

    typedef struct packed {
        logic last;
        res_t res;
    } reply_t;

    logic [OUT_INDEX_W-1:0] spare_slots [SLOTS];
    int                     spare_count;
    logic [GEN_W-1:0]       live_gen   [SLOTS];
    logic [GEN_W-1:0]       next_gen   [SLOTS];
    logic [BITS_W-1:0]      comp_mask  [SLOTS];
    logic [1:0]             slot_mark  [SLOTS];
    reply_t                 due_replies[$];

    initial begin
        error_count = 0;
        outstanding = 0;
    end

    task automatic clear_slots();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            live_gen[i]    = '0;
            next_gen[i]    = '0;
            comp_mask[i]   = '0;
            slot_mark[i]   = MARK_NONE;
            spare_slots[i] = OUT_INDEX_W'(SLOTS - 1 - i);
        end
        spare_count = SLOTS;
        due_replies.delete();
    endtask

    function automatic bit handle_ok(logic [IN_INDEX_W-1:0] idx, logic [GEN_W-1:0] gen);
        if (idx >= SLOTS || gen == '0)
            return 1'b0;
        return live_gen[idx] == gen;
    endfunction

    task automatic queue_reply(logic [STATUS_W-1:0] st, int idx, logic [GEN_W-1:0] gen,
                               logic [BITS_W-1:0] bits, int cnt);
        reply_t rp;
        rp.last               = 1'b0;
        rp.res.status         = st;
        rp.res.out_index      = OUT_INDEX_W'(idx);
        rp.res.out_generation = gen;
        rp.res.out_bits       = bits;
        rp.res.match_count    = COUNT_W'(cnt);
        due_replies.push_back(rp);
    endtask

    // free a slot: bump its generation past zero and push it back
    task automatic retire_slot(int i);
        logic [GEN_W-1:0] g;
        g = live_gen[i] + 1'b1;
        if (g == '0)
            g = GEN_W'(1);
        live_gen[i]  = '0;
        next_gen[i]  = g;
        comp_mask[i] = '0;
        slot_mark[i] = MARK_NONE;
        if (spare_count < SLOTS) begin
            spare_slots[spare_count] = OUT_INDEX_W'(i);
            spare_count++;
        end
    endtask

    task automatic run_command(item_t it);
        int               i;
        int               s;
        int               hits;
        bit               found;
        bit               known;
        logic [GEN_W-1:0] g;
        reply_t           rp;
        known = 1'b1;
        case (it.cmd)
            CMD_CREATE: begin
                if (spare_count == 0) begin
                    queue_reply(ST_NONE, 0, '0, '0, 0);
                end else begin
                    spare_count--;
                    s = int'(spare_slots[spare_count]);
                    g = next_gen[s];
                    if (g == '0)
                        g = GEN_W'(1);
                    live_gen[s]  = g;
                    comp_mask[s] = '0;
                    queue_reply(ST_OK, s, g, '0, 0);
                end
            end
            CMD_DESTROY, CMD_MARK, CMD_ADD_BITS, CMD_CHECK: begin
                s = int'(it.slot_index);
                if (!handle_ok(it.slot_index, it.generation)) begin
                    queue_reply(ST_INVALID, 0, '0, '0, 0);
                end else if (it.cmd == CMD_DESTROY) begin
                    queue_reply(ST_OK, s, it.generation, comp_mask[s], 0);
                    retire_slot(s);
                end else if (it.cmd == CMD_MARK) begin
                    if (slot_mark[s] == MARK_NONE)
                        slot_mark[s] = MARK_MARKED;
                    queue_reply(ST_OK, s, it.generation, '0, 0);
                end else if (it.cmd == CMD_ADD_BITS) begin
                    comp_mask[s] = comp_mask[s] | it.bits;
                    queue_reply(ST_OK, s, it.generation, '0, 0);
                end else begin
                    queue_reply(ST_OK, s, it.generation, comp_mask[s], 0);
                end
            end
            CMD_CLEANUP: begin
                hits = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_mark[i] == MARK_MARKED) begin
                        if (live_gen[i] == '0) begin
                            slot_mark[i] = MARK_NONE;
                        end else begin
                            queue_reply(ST_OK, i, live_gen[i], comp_mask[i], 0);
                            slot_mark[i] = MARK_CLEANED;
                            hits++;
                        end
                    end
                end
                if (hits == 0)
                    queue_reply(ST_NONE, 0, '0, '0, 0);
            end
            CMD_DESTROY_ALL: begin
                hits = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_mark[i] != MARK_NONE) begin
                        if (live_gen[i] == '0) begin
                            slot_mark[i] = MARK_NONE;
                        end else begin
                            // a slot already cleaned has run its hooks
                            queue_reply(ST_OK, i, live_gen[i],
                                        slot_mark[i] == MARK_MARKED ? comp_mask[i] : '0, 0);
                            retire_slot(i);
                            hits++;
                        end
                    end
                end
                if (hits == 0)
                    queue_reply(ST_NONE, 0, '0, '0, 0);
            end
            CMD_COUNT: begin
                hits = 0;
                for (i = 0; i < SLOTS; i++)
                    if (live_gen[i] != '0 && (comp_mask[i] & it.bits) == it.bits)
                        hits++;
                queue_reply(ST_OK, 0, '0, '0, hits);
            end
            CMD_FIND: begin
                found = 1'b0;
                for (i = 0; i < SLOTS && !found; i++) begin
                    if (live_gen[i] != '0 && (comp_mask[i] & it.bits) == it.bits) begin
                        queue_reply(ST_OK, i, live_gen[i], comp_mask[i], 0);
                        found = 1'b1;
                    end
                end
                if (!found)
                    queue_reply(ST_NONE, 0, '0, '0, 0);
            end
            default: known = 1'b0;
        endcase
        if (known) begin
            rp      = due_replies.pop_back();
            rp.last = 1'b1;
            due_replies.push_back(rp);
        end
    endtask

    task automatic report_miss(string what, reply_t want, reply_t got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s", $time, what);
            $display("  expected st=%0d idx=%0d gen=%h bits=%h cnt=%0d last=%0b",
                     want.res.status, want.res.out_index, want.res.out_generation,
                     want.res.out_bits, want.res.match_count, want.last);
            $display("  actual   st=%0d idx=%0d gen=%h bits=%h cnt=%0d last=%0b",
                     got.res.status, got.res.out_index, got.res.out_generation,
                     got.res.out_bits, got.res.match_count, got.last);
        end
    endtask

    always @(posedge aclk) begin : watch
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            clear_slots();
            outstanding <= 0;
        end else begin
            if (s_tvalid && s_tready)
                run_command(item_t'(s_tdata[ITEM_W-1:0]));
            if (m_tvalid && m_tready) begin
                got.res  = res_t'(m_tdata[RES_W-1:0]);
                got.last = m_tlast;
                if (due_replies.size() == 0) begin
                    report_miss("result item with nothing due", '0, got);
                end else begin
                    want = due_replies.pop_front();
                    if (got.res.status != want.res.status
                        || got.res.out_index != want.res.out_index
                        || got.res.out_generation != want.res.out_generation
                        || got.res.out_bits != want.res.out_bits
                        || got.res.match_count != want.res.match_count
                        || got.last != want.last)
                        report_miss("result item mismatch", want, got);
                end
            end
            outstanding <= due_replies.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the generational slot allocator
// Drives a short directed command list through the allocator, then random
// traffic that first fills the slot pool and later mixes all commands over
// handles learned from earlier results. Both channels idle at random, and
// the result side holds off once for a long stretch. The checker does the
// prediction and comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import gsa_pkg::*;

    localparam int SLOTS        = 64;
    localparam int ITEMS        = 250;
    localparam int FILL_ITEMS   = 120;
    localparam int CALM_TAIL    = 40;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 100;
    localparam int DRAIN_CYCLES = 80;
    localparam int POOL_MAX     = 32;
    localparam int RES_W        = $bits(res_t);

    // a code outside the command set
    localparam logic [CMD_W-1:0] CMD_UNUSED = 4'd15;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    int                   error_count;
    int                   outstanding;

    int                   sent_items = 0;
    bit                   calm       = 1'b0;
    logic [IN_INDEX_W-1:0] pool_idx [POOL_MAX];
    logic [GEN_W-1:0]      pool_gen [POOL_MAX];
    int                    pool_n     = 0;

    always #10 aclk = ~aclk;

    generational_slot_allocator #(
        .SLOTS     (SLOTS),
        .GEN_BITS  (GEN_W),
        .MASK_BITS (BITS_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    gsa_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    function automatic item_t make_item(logic [CMD_W-1:0] cmd, logic [IN_INDEX_W-1:0] idx,
                                        logic [GEN_W-1:0] gen, logic [BITS_W-1:0] bits);
        item_t it;
        it.cmd        = cmd;
        it.slot_index = idx;
        it.generation = gen;
        it.bits       = bits;
        return it;
    endfunction

    task automatic send_cmd(item_t it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ITEM_W){1'b0}}, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (it.cmd <= CMD_FIND)
            sent_items++;
    endtask

    function automatic item_t random_item(bit filling);
        item_t it;
        int    r;
        int    k;
        it.bits = $urandom();
        r = $urandom_range(0, 99);
        if (r < (filling ? 60 : 18)) begin
            it.cmd = CMD_CREATE;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 12)      it.cmd = CMD_DESTROY;
            else if (r < 28) it.cmd = CMD_MARK;
            else if (r < 46) it.cmd = CMD_ADD_BITS;
            else if (r < 62) it.cmd = CMD_CHECK;
            else if (r < 72) it.cmd = CMD_CLEANUP;
            else if (r < 80) it.cmd = CMD_DESTROY_ALL;
            else if (r < 88) it.cmd = CMD_COUNT;
            else if (r < 97) it.cmd = CMD_FIND;
            else             it.cmd = CMD_W'($urandom_range(9, 15));
        end
        if (pool_n > 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, pool_n - 1);
            it.slot_index = pool_idx[k];
            it.generation = pool_gen[k];
            if ($urandom_range(0, 15) == 0)
                it.generation = it.generation + 1'b1;
        end else begin
            it.slot_index = IN_INDEX_W'($urandom_range(0, 255));
            it.generation = GEN_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0)
                it.generation = GEN_W'($urandom_range(0, 3));
        end
        r = $urandom_range(0, 9);
        if (it.cmd == CMD_COUNT || it.cmd == CMD_FIND) begin
            // mostly narrow queries so that live slots match
            if (r < 6)      it.bits = $urandom_range(0, 7);
            else if (r < 8) it.bits = '0;
            else if (r < 9) it.bits = 32'h1 << $urandom_range(0, 31);
        end else if (it.cmd == CMD_ADD_BITS) begin
            if (r < 4)      it.bits = $urandom_range(1, 15);
            else if (r < 7) it.bits = 32'h1 << $urandom_range(0, 31);
        end
        return it;
    endfunction

    // learn live handles from the result stream
    always @(posedge aclk) begin : learn
        res_t seen;
        int   k;
        bit   have;
        if (aresetn && m_tvalid && m_tready) begin
            seen = res_t'(m_tdata[RES_W-1:0]);
            if (seen.status == ST_OK && seen.out_generation != '0) begin
                have = 1'b0;
                for (k = 0; k < pool_n; k++)
                    if (pool_idx[k] == IN_INDEX_W'(seen.out_index)
                        && pool_gen[k] == seen.out_generation)
                        have = 1'b1;
                if (!have) begin
                    k = (pool_n < POOL_MAX) ? pool_n : $urandom_range(0, POOL_MAX - 1);
                    pool_idx[k] = IN_INDEX_W'(seen.out_index);
                    pool_gen[k] = seen.out_generation;
                    if (pool_n < POOL_MAX)
                        pool_n++;
                end
            end
        end
    end

    initial begin : receiver
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!held && sent_items >= HOLD_AT) begin
                // long hold-off so the allocator backs up into its input
                held       = 1'b1;
                stall_left = LONG_HOLD - 1;
                m_tready   <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int first_random;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty allocator: nothing to find, zero count, null generation
        send_cmd(make_item(CMD_FIND,        8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_COUNT,       8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_CHECK,       8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_CREATE,      8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_CREATE,      8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_CHECK,       8'd0,   16'd1,      32'h0));
        send_cmd(make_item(CMD_ADD_BITS,    8'd0,   16'd1,      32'hFFFF_FFFF));
        send_cmd(make_item(CMD_ADD_BITS,    8'd1,   16'd1,      32'h0000_0001));
        // out of range index and stale generation
        send_cmd(make_item(CMD_CHECK,       8'd255, 16'd1,      32'h0));
        send_cmd(make_item(CMD_CHECK,       8'd64,  16'd1,      32'h0));
        send_cmd(make_item(CMD_CHECK,       8'd0,   16'hFFFF,   32'h0));
        send_cmd(make_item(CMD_COUNT,       8'd0,   16'd0,      32'hFFFF_FFFF));
        send_cmd(make_item(CMD_FIND,        8'd0,   16'd0,      32'h8000_0000));
        send_cmd(make_item(CMD_MARK,        8'd1,   16'd1,      32'h0));
        send_cmd(make_item(CMD_MARK,        8'd1,   16'd1,      32'h0));
        send_cmd(make_item(CMD_CLEANUP,     8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_CLEANUP,     8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_MARK,        8'd0,   16'd1,      32'h0));
        // marked slot reports its mask, cleaned slot reports none
        send_cmd(make_item(CMD_DESTROY_ALL, 8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_DESTROY_ALL, 8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_CREATE,      8'd0,   16'd0,      32'h0));
        send_cmd(make_item(CMD_DESTROY,     8'd1,   16'd2,      32'h0));
        send_cmd(make_item(CMD_DESTROY,     8'd1,   16'd2,      32'h0));
        send_cmd(make_item(CMD_MARK,        8'd200, 16'd1,      32'h0));
        send_cmd(make_item(CMD_UNUSED,      8'hFF,  16'hFFFF,   32'hFFFF_FFFF));

        first_random = sent_items;
        while (sent_items - first_random < ITEMS) begin
            calm = (ITEMS - (sent_items - first_random)) <= CALM_TAIL;
            send_cmd(random_item((sent_items - first_random) < FILL_ITEMS));
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
